// ===== rtl/mst_pkg.sv =====
// Shared types and constants for the membership set table.
// Holds operation and status codes, field widths and the result struct.
// No dependencies.
package mst_pkg;

  // Fixed field widths
  localparam int ID_W            = 31;
  localparam int COUNT_W         = 7;
  localparam int LIMIT_W         = 7;
  localparam int MAX_MEMBERS_DEF = 64;

  // Register selector: word bit of paddr that picks the register
  localparam logic REG_MEMBER_LIMIT = 1'b0;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_ABSENT    = 3'd4,
    ST_FOUND     = 3'd5,
    ST_NOT_FOUND = 3'd6
  } status_t;

  typedef struct packed {
    status_t              status;
    logic [COUNT_W-1:0]   member_count;
  } result_t;

endpackage

// ===== rtl/mst_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module mst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/mst_ctrl.sv =====
// Sequencer of the membership set table: scans the slot RAM one entry at a
// time through a single comparator, appends on add and compacts on remove.
// Depends on mst_pkg.
module mst_ctrl import mst_pkg::*; #(
  parameter int MAX_MEMBERS = MAX_MEMBERS_DEF,
  localparam int AW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         operation,
  input  logic [ID_W-1:0]    member_id,
  input  logic [LIMIT_W-1:0] member_limit,
  output logic               busy,
  output logic               done,
  output result_t            result,
  output logic               ram_we,
  output logic [AW-1:0]      ram_waddr,
  output logic [ID_W-1:0]    ram_wdata,
  output logic [AW-1:0]      ram_raddr,
  input  logic [ID_W-1:0]    ram_rdata
);

  localparam int CW = $clog2(MAX_MEMBERS + 1);
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CMP,
    S_SHIFT,
    S_MOVE
  } state_t;

  state_t            state;
  logic [1:0]        op_q;
  logic [ID_W-1:0]   id_q;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     live_count;
  status_t           status_q;

  logic [LW-1:0]     cnt_ext;
  logic [LW-1:0]     lim_ext;
  logic [CW-1:0]     idx_inc;
  logic              at_limit;
  logic              scan_end;
  logic              shift_end;
  logic              hit;
  logic              is_add;
  logic              is_remove;

  // Decode the held transaction and compare the slot just read
  assign is_add    = (op_q == OP_ADD);
  assign is_remove = (op_q == OP_REMOVE);
  assign cnt_ext   = LW'(live_count);
  assign lim_ext   = LW'(member_limit);
  assign at_limit  = (cnt_ext >= lim_ext) || (live_count >= CW'(MAX_MEMBERS));
  assign idx_inc   = idx + 1'b1;
  assign scan_end  = (idx == live_count);
  assign shift_end = (idx_inc >= live_count);
  assign hit       = (ram_rdata == id_q);

  // RAM ports: append on add, move one slot down while compacting
  always_comb begin
    ram_raddr = (state == S_SHIFT) ? idx_inc[AW-1:0] : idx[AW-1:0];
    ram_we    = ((state == S_SCAN) && is_add && !at_limit && scan_end) ||
                (state == S_MOVE);
    ram_waddr = (state == S_MOVE) ? idx[AW-1:0] : live_count[AW-1:0];
    ram_wdata = (state == S_MOVE) ? ram_rdata : id_q;
  end

  // Sequencer, count and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      live_count <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op_q  <= operation;
            id_q  <= member_id;
            idx   <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (is_add && at_limit) begin
            status_q <= ST_FULL;
            done     <= 1'b1;
            state    <= S_IDLE;
          end else if (scan_end) begin
            if (is_add) begin
              live_count <= live_count + 1'b1;
              status_q   <= ST_ADDED;
            end else if (is_remove) begin
              status_q <= ST_ABSENT;
            end else begin
              status_q <= ST_NOT_FOUND;
            end
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (hit) begin
            if (is_remove) begin
              state <= S_SHIFT;
            end else begin
              status_q <= is_add ? ST_DUPLICATE : ST_FOUND;
              done     <= 1'b1;
              state    <= S_IDLE;
            end
          end else begin
            idx   <= idx_inc;
            state <= S_SCAN;
          end
        end
        S_SHIFT: begin
          if (shift_end) begin
            live_count <= live_count - 1'b1;
            status_q   <= ST_REMOVED;
            done       <= 1'b1;
            state      <= S_IDLE;
          end else begin
            state <= S_MOVE;
          end
        end
        S_MOVE: begin
          idx   <= idx_inc;
          state <= S_SHIFT;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  // Count after the transaction, masked to the field width
  always_comb begin
    result.status       = status_q;
    result.member_count = cnt_ext[COUNT_W-1:0];
  end

endmodule

// ===== rtl/membership_set_table.sv =====
// Membership set table: insertion-ordered list of distinct identifiers.
// A full add is refused at once; otherwise the slots are compared one by one until a match
// or the end of the list, and a remove then moves every later slot down one place.
// Throughput: one transaction at a time; the next is taken at the edge that takes the result.
// Reset clears the count and the limit; slot contents stay undefined. Results cannot stall.
module membership_set_table import mst_pkg::*; #(
  parameter int MAX_MEMBERS = MAX_MEMBERS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation,
  input  logic [ID_W-1:0]    member_id,
  output logic               done,
  output logic [2:0]         status,
  output logic [COUNT_W-1:0] member_count,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;

  logic [LIMIT_W-1:0] member_limit;
  result_t            result;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ID_W-1:0]    ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [ID_W-1:0]    ram_rdata;
  logic               reg_sel;

  // Configuration register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_MEMBER_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      member_limit <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      member_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  assign prdata = reg_sel ? {{(32-LIMIT_W){1'b0}}, member_limit} : 32'd0;

  // Slot storage
  mst_ram #(
    .WIDTH (ID_W),
    .DEPTH (MAX_MEMBERS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer
  mst_ctrl #(
    .MAX_MEMBERS (MAX_MEMBERS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .operation    (operation),
    .member_id    (member_id),
    .member_limit (member_limit),
    .busy         (busy),
    .done         (done),
    .result       (result),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata)
  );

  assign status       = result.status;
  assign member_count = result.member_count;

  // An accepted transaction always occupies the sequencer next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not make the block busy");

  // The result strobe comes only once the sequencer has returned to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while sequencer busy");

  // One strobe per transaction: never two in a row
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe repeated");

  // A refused add never changes the count
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_FULL)) |-> $stable(member_count))
    else $error("count changed on a full add");

endmodule

// ===== test/tb_membership_set_table.sv =====
// Self-checking testbench for the membership set table: command port, result strobe and
// the APB member_limit register, checked against an in-bench predictor of the member list.
// Depends on rtl/mst_pkg.sv and rtl/membership_set_table.sv.
module tb_membership_set_table;
  import mst_pkg::*;

  localparam logic [1:0] OP_SPARE    = 2'd3;  // unused code, behaves as a query
  localparam logic [2:0] LIMIT_ADDR  = {REG_MEMBER_LIMIT, 2'b00};
  localparam int         ITEM_TARGET = 1550;
  localparam int         SETTLE_CYC  = 300;   // beyond the longest remove of a full list
  localparam int         REPORT_MAX  = 10;

  typedef enum logic [1:0] {ENT_CMD, ENT_LIMIT, ENT_DRAIN} entry_kind_t;
  typedef enum logic [2:0] {
    DRV_FETCH, DRV_GAP, DRV_CMD, DRV_QUIET, DRV_SETUP, DRV_ACCESS
  } drv_state_t;

  typedef struct {
    entry_kind_t     kind;
    logic [1:0]      op;
    logic [ID_W-1:0] id;
    logic [31:0]     wdata;
    int              gap;
  } pending_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         operation = OP_QUERY;
  logic [ID_W-1:0]    member_id = '0;
  logic               done;
  logic [2:0]         status;
  logic [COUNT_W-1:0] member_count;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = LIMIT_ADDR;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // Stimulus and expectation stores
  pending_t        pending_q[$];
  result_t         expected_results[$];
  logic [ID_W-1:0] id_pool[$];
  pending_t        cur_entry;
  drv_state_t      drv_state = DRV_FETCH;
  int              gap_left;
  bit              steady_sender;

  // Predictor copy of the member list
  logic [ID_W-1:0]    held_ids[MAX_MEMBERS_DEF];
  int unsigned        held_count = 0;
  logic [LIMIT_W-1:0] limit_shadow = '0;

  // Run statistics
  int items_queued = 0;
  int items_sent = 0;
  int limit_writes = 0;
  int mismatches = 0;
  int peak_count = 0;
  int status_seen[7];

  membership_set_table u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .member_id    (member_id),
    .done         (done),
    .status       (status),
    .member_count (member_count),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one transaction to the predicted list and return the status and count it gives
  function automatic result_t apply_membership_op(input logic [1:0] op,
                                                  input logic [ID_W-1:0] id);
    result_t     r;
    int unsigned cap;
    int unsigned pos;
    cap = (limit_shadow < MAX_MEMBERS_DEF) ? limit_shadow : MAX_MEMBERS_DEF;
    pos = held_count;
    for (int k = held_count - 1; k >= 0; k--) begin
      if (held_ids[k] == id) pos = k;
    end
    case (op)
      OP_ADD: begin
        if (held_count >= cap) begin
          r.status = ST_FULL;
        end else if (pos < held_count) begin
          r.status = ST_DUPLICATE;
        end else begin
          held_ids[held_count] = id;
          held_count++;
          r.status = ST_ADDED;
        end
      end
      OP_REMOVE: begin
        if (pos < held_count) begin
          for (int k = pos; k + 1 < held_count; k++) held_ids[k] = held_ids[k + 1];
          held_count--;
          r.status = ST_REMOVED;
        end else begin
          r.status = ST_ABSENT;
        end
      end
      default: begin
        r.status = (pos < held_count) ? ST_FOUND : ST_NOT_FOUND;
      end
    endcase
    r.member_count = COUNT_W'(held_count);
    if (held_count > peak_count) peak_count = held_count;
    return r;
  endfunction

  // Take the next pending entry; raise start at once for a command with no gap
  task automatic advance_driver();
    if (pending_q.size() == 0) begin
      start <= 1'b0;
      drv_state <= DRV_FETCH;
    end else begin
      cur_entry = pending_q.pop_front();
      gap_left = cur_entry.gap;
      if (cur_entry.kind == ENT_CMD && gap_left == 0) begin
        start <= 1'b1;
        operation <= cur_entry.op;
        member_id <= cur_entry.id;
        drv_state <= DRV_CMD;
      end else begin
        start <= 1'b0;
        drv_state <= (cur_entry.kind == ENT_CMD) ? DRV_GAP : DRV_QUIET;
      end
    end
  endtask

  // Driver: commands on start/busy, limit writes over APB while the block is idle
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      drv_state <= DRV_FETCH;
    end else begin
      case (drv_state)
        DRV_FETCH: begin
          if (pending_q.size() != 0) advance_driver();
        end
        DRV_GAP: begin
          if (gap_left <= 1) begin
            start <= 1'b1;
            operation <= cur_entry.op;
            member_id <= cur_entry.id;
            drv_state <= DRV_CMD;
          end else begin
            gap_left--;
          end
        end
        DRV_CMD: begin
          if (!busy) begin
            expected_results.push_back(apply_membership_op(cur_entry.op, cur_entry.id));
            items_sent++;
            advance_driver();
          end
        end
        DRV_QUIET: begin
          // hold until every expected result is back and the block is free
          if (expected_results.size() == 0 && !busy) begin
            if (cur_entry.kind == ENT_LIMIT) begin
              psel <= 1'b1;
              penable <= 1'b0;
              pwrite <= 1'b1;
              paddr <= LIMIT_ADDR;
              pwdata <= cur_entry.wdata;
              drv_state <= DRV_SETUP;
            end else begin
              advance_driver();
            end
          end
        end
        DRV_SETUP: begin
          penable <= 1'b1;
          drv_state <= DRV_ACCESS;
        end
        DRV_ACCESS: begin
          if (pready) begin
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
            limit_shadow = cur_entry.wdata[LIMIT_W-1:0];
            limit_writes++;
            advance_driver();
          end
        end
        default: drv_state <= DRV_FETCH;
      endcase
    end
  end

  // Monitor: compare each strobed result with the oldest expectation
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: status %0d count %0d", status, member_count);
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status || member_count !== want.member_count) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("mismatch at result %0d: status exp %0d got %0d, count exp %0d got %0d",
                     items_sent - expected_results.size(), want.status, status,
                     want.member_count, member_count);
        end else begin
          status_seen[status]++;
        end
      end
    end
  end

  task automatic queue_command(input logic [1:0] op, input logic [ID_W-1:0] id);
    pending_t e;
    e.kind = ENT_CMD;
    e.op = op;
    e.id = id;
    e.wdata = '0;
    e.gap = steady_sender ? 0 : $urandom_range(0, 6);
    pending_q.push_back(e);
    items_queued++;
  endtask

  task automatic queue_limit(input logic [LIMIT_W-1:0] value);
    pending_t e;
    e.kind = ENT_LIMIT;
    e.op = OP_QUERY;
    e.id = '0;
    // upper data bits carry noise that the register must drop
    e.wdata = {($urandom_range(0, 1) == 1) ? 25'($urandom) : 25'd0, value};
    e.gap = 0;
    pending_q.push_back(e);
  endtask

  task automatic queue_drain();
    pending_t e;
    e.kind = ENT_DRAIN;
    e.op = OP_QUERY;
    e.id = '0;
    e.wdata = '0;
    e.gap = 0;
    pending_q.push_back(e);
  endtask

  // Fill the identifier pool: all zeros, all ones, random and small values, and near neighbours one bit from a base
  task automatic refill_pool(input int n);
    logic [ID_W-1:0] base;
    id_pool.delete();
    base = ID_W'($urandom);
    id_pool.push_back('0);
    id_pool.push_back({ID_W{1'b1}});
    for (int i = 2; i < n; i++) begin
      case (i % 4)
        0: id_pool.push_back(ID_W'($urandom));
        1: id_pool.push_back(base ^ (ID_W'(1) << $urandom_range(0, ID_W - 1)));
        2: id_pool.push_back(~base ^ ID_W'(i));
        default: id_pool.push_back(ID_W'($urandom_range(0, 15)));
      endcase
    end
  endtask

  initial begin : stimulus
    logic [LIMIT_W-1:0] limit_plan[12] = '{64, 10, 127, 0, 5, 64, 1, 33, 100, 2, 64, 20};
    logic [LIMIT_W-1:0] lim;
    logic [ID_W-1:0]    id;
    logic [1:0]         op;
    int                 phase;
    int                 pick;
    int                 add_pct;
    int                 rem_pct;

    // Directed: zero limit after reset refuses every add
    steady_sender = 1'b0;
    queue_command(OP_ADD, '0);
    queue_command(OP_QUERY, '0);
    queue_command(OP_REMOVE, '0);
    queue_command(OP_SPARE, '0);
    queue_drain();
    // Small limit: fill, duplicate, full before duplicate, spare code as a query
    queue_limit(7'd3);
    queue_command(OP_ADD, '0);
    queue_command(OP_ADD, {ID_W{1'b1}});
    queue_command(OP_ADD, '0);
    queue_command(OP_ADD, 31'h5555_5555);
    queue_command(OP_ADD, 31'h2AAA_AAAA);
    queue_command(OP_ADD, '0);
    queue_command(OP_QUERY, {ID_W{1'b1}});
    queue_command(OP_SPARE, '0);
    // Remove the head entry so later entries move down
    queue_command(OP_REMOVE, '0);
    queue_command(OP_QUERY, '0);
    queue_command(OP_REMOVE, '0);
    queue_command(OP_QUERY, 31'h5555_5555);
    // Limit below the count: members stay, adds are refused until removes bring the count under it
    queue_limit(7'd1);
    queue_command(OP_ADD, 31'h2AAA_AAAA);
    queue_command(OP_REMOVE, {ID_W{1'b1}});
    queue_command(OP_QUERY, 31'h5555_5555);
    queue_command(OP_ADD, 31'h2AAA_AAAA);
    queue_command(OP_REMOVE, 31'h5555_5555);
    queue_command(OP_ADD, 31'h2AAA_AAAA);

    // Random phases; the count carries over, so a high-limit fill precedes a low limit
    refill_pool(80);
    phase = 0;
    while (items_queued < ITEM_TARGET) begin
      lim = limit_plan[phase % 12];
      if (phase % 5 == 4) lim = LIMIT_W'($urandom_range(0, 127));
      add_pct = (lim >= 33) ? 65 : 40;
      rem_pct = (lim >= 33) ? 15 : 30;
      steady_sender = (phase % 4 == 2);
      if (lim >= 33 && phase != 0) refill_pool(80);
      queue_limit(lim);
      for (int n = 0; n < 140 && items_queued < ITEM_TARGET; n++) begin
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0) id = ID_W'($urandom);
        else id = id_pool[$urandom_range(0, id_pool.size() - 1)];
        if (pick < add_pct) op = OP_ADD;
        else if (pick < add_pct + rem_pct) op = OP_REMOVE;
        else if (pick < 96) op = OP_QUERY;
        else op = OP_SPARE;
        queue_command(op, id);
        if ($urandom_range(0, 79) == 0) queue_drain();
      end
      phase++;
    end

    @(posedge clk);
    @(posedge clk);
    rst <= 1'b0;

    // Wait for the stimulus to drain and every result to arrive
    while (pending_q.size() != 0 || drv_state != DRV_FETCH || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);

    $display("summary: %0d commands, %0d limit writes, peak count %0d",
             items_sent, limit_writes, peak_count);
    $display("summary: added %0d dup %0d full %0d removed %0d absent %0d found %0d missing %0d",
             status_seen[ST_ADDED], status_seen[ST_DUPLICATE], status_seen[ST_FULL],
             status_seen[ST_REMOVED], status_seen[ST_ABSENT], status_seen[ST_FOUND],
             status_seen[ST_NOT_FOUND]);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond a run where every remove walks a full list
  initial begin : watchdog
    #8000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/mst_pkg.sv
rtl/mst_ram.sv
rtl/mst_ctrl.sv
rtl/membership_set_table.sv
test/tb_membership_set_table.sv
